/* sv/pkvsm_pkg.sv */
// Shared constants, types and helper functions for the paged KV slot mapper.
// Used by every module of the block except pkvsm_ram; depends on nothing.
package pkvsm_pkg;

   // Table geometry.
   localparam int MAX_REQUESTS           = 256;
   localparam int MAX_BLOCKS_PER_REQUEST = 64;
   localparam int BLOCK_ID_BITS          = 24;
   localparam int ROW_BITS               = $clog2(MAX_REQUESTS);
   localparam int TBL_COL_BITS           = $clog2(MAX_BLOCKS_PER_REQUEST);
   localparam int TABLE_DEPTH            = MAX_REQUESTS * MAX_BLOCKS_PER_REQUEST;

   // Field widths of the channels.
   localparam int REQ_W   = 8;
   localparam int COL_W   = 6;
   localparam int ENTRY_W = 24;
   localparam int POS_W   = 24;
   localparam int SEQ_W   = 25;
   localparam int SLOT_W  = 35;

   // Configuration register widths.
   localparam int BS_W   = 11;
   localparam int LEN_W  = 25;
   localparam int BPR_W  = 7;
   localparam int PAD_W  = 32;
   localparam int ACT_W  = 9;

   // Product of a block id and the block size.
   localparam int PROD_W = BLOCK_ID_BITS + BS_W;

   // Divider: quotient bits resolved per pipeline stage.
   localparam int DIV_BITS_PER_STAGE = 2;
   localparam int DIV_STAGES         = POS_W / DIV_BITS_PER_STAGE;

   // Configuration port.
   localparam int NUM_REGS    = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_IDX_LSB = 2;
   localparam int CSR_ADDR_W  = $clog2(NUM_REGS * 4);
   localparam int CSR_IDX_W   = CSR_ADDR_W - CSR_IDX_LSB;

   localparam logic [CSR_IDX_W-1:0] REG_BLOCK_SIZE      = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_MAX_MODEL_LEN   = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_BLOCKS_PER_REQ  = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_PAD_VALUE       = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] REG_ACTIVE_REQUESTS = CSR_IDX_W'(4);

   // Reset values of the registers.
   localparam logic [BS_W-1:0]  RST_BLOCK_SIZE      = BS_W'(16);
   localparam logic [LEN_W-1:0] RST_MAX_MODEL_LEN   = LEN_W'(4096);
   localparam logic [BPR_W-1:0] RST_BLOCKS_PER_REQ  = BPR_W'(64);
   localparam logic [PAD_W-1:0] RST_PAD_VALUE       = '1;
   localparam logic [ACT_W-1:0] RST_ACTIVE_REQUESTS = '0;

   // Positions never exceed the position field, so the limit is capped there.
   localparam logic [LEN_W-1:0] POS_LIMIT_CAP = LEN_W'(1) << POS_W;

   localparam logic KIND_WRITE   = 1'b0;
   localparam logic KIND_COMPUTE = 1'b1;

   // Effective configuration as seen by the datapath.
   typedef struct packed {
      logic [BS_W-1:0]         block_size;
      logic [LEN_W-1:0]        limit;
      logic [TBL_COL_BITS-1:0] last_column;
      logic [PAD_W-1:0]        pad_value;
      logic [ACT_W-1:0]        active_requests;
   } cfg_type;

   // One item as it travels down the pipeline.
   typedef struct packed {
      logic               kind;
      logic [REQ_W-1:0]   request;
      logic [COL_W-1:0]   column;
      logic [ENTRY_W-1:0] entry;
      logic               padded;
      logic               wrap;
      logic [POS_W-1:0]   next_pos;
      logic [SEQ_W-1:0]   new_seq;
   } item_type;

   // Partial quotient and remainder of the divider.
   typedef struct packed {
      logic [BS_W-1:0]  rem;
      logic [POS_W-1:0] quo;
   } quot_type;

   // One restoring division step: returns the quotient bit on top of the
   // new remainder.
   function automatic logic [BS_W:0] div_step(input logic [BS_W-1:0] rem,
                                               input logic            din,
                                               input logic [BS_W-1:0] divisor);
      logic [BS_W:0] trial;
      logic [BS_W:0] diff;
      trial = {rem, din};
      diff  = trial - {1'b0, divisor};
      if (trial >= {1'b0, divisor}) begin
         return {1'b1, diff[BS_W-1:0]};
      end
      return {1'b0, trial[BS_W-1:0]};
   endfunction

endpackage

/* sv/pkvsm_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; holds the block table of the slot mapper.
module pkvsm_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/pkvsm_csr.sv */
// Configuration registers of the slot mapper behind an APB-style port.
// Depends on pkvsm_pkg; presents the effective settings as a cfg_type struct.
module pkvsm_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [pkvsm_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [pkvsm_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [pkvsm_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                              csr_pready,
   output pkvsm_pkg::cfg_type                cfg
);

   logic [pkvsm_pkg::BS_W-1:0]  block_size_ff;
   logic [pkvsm_pkg::LEN_W-1:0] max_model_len_ff;
   logic [pkvsm_pkg::BPR_W-1:0] blocks_per_req_ff;
   logic [pkvsm_pkg::PAD_W-1:0] pad_value_ff;
   logic [pkvsm_pkg::ACT_W-1:0] active_requests_ff;

   logic                             wr_en;
   logic [pkvsm_pkg::CSR_IDX_W-1:0]  reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[pkvsm_pkg::CSR_ADDR_W-1:pkvsm_pkg::CSR_IDX_LSB];

   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff      <= pkvsm_pkg::RST_BLOCK_SIZE;
         max_model_len_ff   <= pkvsm_pkg::RST_MAX_MODEL_LEN;
         blocks_per_req_ff  <= pkvsm_pkg::RST_BLOCKS_PER_REQ;
         pad_value_ff       <= pkvsm_pkg::RST_PAD_VALUE;
         active_requests_ff <= pkvsm_pkg::RST_ACTIVE_REQUESTS;
      end else if (wr_en) begin
         unique case (reg_idx)
            pkvsm_pkg::REG_BLOCK_SIZE: begin
               block_size_ff <= csr_pwdata[pkvsm_pkg::BS_W-1:0];
            end
            pkvsm_pkg::REG_MAX_MODEL_LEN: begin
               max_model_len_ff <= csr_pwdata[pkvsm_pkg::LEN_W-1:0];
            end
            pkvsm_pkg::REG_BLOCKS_PER_REQ: begin
               blocks_per_req_ff <= csr_pwdata[pkvsm_pkg::BPR_W-1:0];
            end
            pkvsm_pkg::REG_PAD_VALUE: begin
               pad_value_ff <= csr_pwdata[pkvsm_pkg::PAD_W-1:0];
            end
            pkvsm_pkg::REG_ACTIVE_REQUESTS: begin
               active_requests_ff <= csr_pwdata[pkvsm_pkg::ACT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         pkvsm_pkg::REG_BLOCK_SIZE:      csr_prdata = pkvsm_pkg::CSR_DATA_W'(block_size_ff);
         pkvsm_pkg::REG_MAX_MODEL_LEN:   csr_prdata = pkvsm_pkg::CSR_DATA_W'(max_model_len_ff);
         pkvsm_pkg::REG_BLOCKS_PER_REQ:  csr_prdata = pkvsm_pkg::CSR_DATA_W'(blocks_per_req_ff);
         pkvsm_pkg::REG_PAD_VALUE:       csr_prdata = pkvsm_pkg::CSR_DATA_W'(pad_value_ff);
         pkvsm_pkg::REG_ACTIVE_REQUESTS: csr_prdata = pkvsm_pkg::CSR_DATA_W'(active_requests_ff);
         default:                        csr_prdata = '0;
      endcase
   end

   // A block size of zero acts as one, a limit is capped at the position
   // range, and the blocks in use are clamped to one through the table width.
   always_comb begin
      cfg.block_size = (block_size_ff == '0) ? pkvsm_pkg::BS_W'(1) : block_size_ff;
      cfg.limit      = (max_model_len_ff > pkvsm_pkg::POS_LIMIT_CAP) ?
                       pkvsm_pkg::POS_LIMIT_CAP : max_model_len_ff;
      if (blocks_per_req_ff == '0) begin
         cfg.last_column = '0;
      end else if (blocks_per_req_ff > pkvsm_pkg::BPR_W'(pkvsm_pkg::MAX_BLOCKS_PER_REQUEST)) begin
         cfg.last_column = pkvsm_pkg::TBL_COL_BITS'(pkvsm_pkg::MAX_BLOCKS_PER_REQUEST - 1);
      end else begin
         cfg.last_column = pkvsm_pkg::TBL_COL_BITS'(blocks_per_req_ff - pkvsm_pkg::BPR_W'(1));
      end
      cfg.pad_value       = pad_value_ff;
      cfg.active_requests = active_requests_ff;
   end

endmodule

/* sv/pkvsm_prep.sv */
// Input register and position/length update stage of the slot mapper.
// Depends on pkvsm_pkg; feeds the divider with one item_type per cycle while advance is high.
module pkvsm_prep (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  logic                            req_valid,
   input  logic                            req_kind,
   input  logic [pkvsm_pkg::REQ_W-1:0]     req_request,
   input  logic [pkvsm_pkg::COL_W-1:0]     req_table_column,
   input  logic [pkvsm_pkg::ENTRY_W-1:0]   req_entry_block,
   input  logic [pkvsm_pkg::POS_W-1:0]     req_position,
   input  logic [pkvsm_pkg::SEQ_W-1:0]     req_seq_length,
   input  pkvsm_pkg::cfg_type              cfg,
   output logic                            out_valid,
   output pkvsm_pkg::item_type             out_item
);

   logic                            in_valid_ff;
   logic                            in_kind_ff;
   logic [pkvsm_pkg::REQ_W-1:0]     in_request_ff;
   logic [pkvsm_pkg::COL_W-1:0]     in_column_ff;
   logic [pkvsm_pkg::ENTRY_W-1:0]   in_entry_ff;
   logic [pkvsm_pkg::POS_W-1:0]     in_pos_ff;
   logic [pkvsm_pkg::SEQ_W-1:0]     in_seq_ff;

   logic                            item_valid_ff;
   pkvsm_pkg::item_type             item_ff;
   pkvsm_pkg::item_type             item_in;

   logic [pkvsm_pkg::LEN_W-1:0]     pos_inc;
   logic [pkvsm_pkg::SEQ_W:0]       seq_inc;
   logic [pkvsm_pkg::SEQ_W:0]       seq_raw;
   logic [pkvsm_pkg::POS_W-1:0]     cpos;
   logic [pkvsm_pkg::SEQ_W-1:0]     nseq;
   logic                            padded;
   logic                            wrap;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         item_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff   <= req_valid;
         item_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_kind_ff    <= req_kind;
         in_request_ff <= req_request;
         in_column_ff  <= req_table_column;
         in_entry_ff   <= req_entry_block;
         in_pos_ff     <= req_position;
         in_seq_ff     <= req_seq_length;
         item_ff       <= item_in;
      end
   end

   always_comb begin
      padded  = ({1'b0, in_request_ff} >= cfg.active_requests) ||
                (32'(in_request_ff) >= pkvsm_pkg::MAX_REQUESTS);
      pos_inc = {1'b0, in_pos_ff} + pkvsm_pkg::LEN_W'(1);
      wrap    = pos_inc >= cfg.limit;
      cpos    = wrap ? '0 : pos_inc[pkvsm_pkg::POS_W-1:0];
      seq_inc = {1'b0, in_seq_ff} + (pkvsm_pkg::SEQ_W + 1)'(1);
      // On a wrap the sequence restarts at one; either way it saturates at the limit.
      seq_raw = wrap ? (pkvsm_pkg::SEQ_W + 1)'(1) : seq_inc;
      nseq    = (seq_raw > {1'b0, cfg.limit}) ? cfg.limit : seq_raw[pkvsm_pkg::SEQ_W-1:0];

      item_in.kind     = in_kind_ff;
      item_in.request  = in_request_ff;
      item_in.column   = in_column_ff;
      item_in.entry    = in_entry_ff;
      item_in.padded   = padded;
      item_in.wrap     = wrap;
      item_in.next_pos = padded ? in_pos_ff : cpos;
      item_in.new_seq  = padded ? in_seq_ff : nseq;
   end

   assign out_valid = item_valid_ff;
   assign out_item  = item_ff;

endmodule

/* sv/pkvsm_div.sv */
// Pipelined restoring divider: next position over block size, DIV_BITS_PER_STAGE
// quotient bits per stage. Depends on pkvsm_pkg; the item rides along.
module pkvsm_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic [pkvsm_pkg::BS_W-1:0]    divisor,
   input  logic                          in_valid,
   input  pkvsm_pkg::item_type           in_item,
   output logic                          out_valid,
   output pkvsm_pkg::item_type           out_item,
   output pkvsm_pkg::quot_type           out_quot
);

   localparam int NST = pkvsm_pkg::DIV_STAGES;

   logic                valid_ff [NST];
   pkvsm_pkg::item_type item_ff  [NST];
   pkvsm_pkg::quot_type quot_ff  [NST];
   pkvsm_pkg::quot_type quot_in  [NST];

   for (genvar k = 0; k < NST; k++) begin : g_stage
      localparam int HI = pkvsm_pkg::POS_W - 1 - pkvsm_pkg::DIV_BITS_PER_STAGE * k;

      logic                prev_valid;
      pkvsm_pkg::item_type prev_item;
      pkvsm_pkg::quot_type prev_quot;

      if (k == 0) begin : g_first
         assign prev_valid = in_valid;
         assign prev_item  = in_item;
         assign prev_quot  = '0;
      end else begin : g_next
         assign prev_valid = valid_ff[k-1];
         assign prev_item  = item_ff[k-1];
         assign prev_quot  = quot_ff[k-1];
      end

      // The dividend bits are taken from the item's position, most significant first.
      always_comb begin
         logic [pkvsm_pkg::BS_W:0]  step;
         logic [pkvsm_pkg::BS_W-1:0] rem_v;
         logic [pkvsm_pkg::POS_W-1:0] quo_v;
         rem_v = prev_quot.rem;
         quo_v = prev_quot.quo;
         for (int j = 0; j < pkvsm_pkg::DIV_BITS_PER_STAGE; j++) begin
            step          = pkvsm_pkg::div_step(rem_v, prev_item.next_pos[HI-j], divisor);
            quo_v[HI-j]   = step[pkvsm_pkg::BS_W];
            rem_v         = step[pkvsm_pkg::BS_W-1:0];
         end
         quot_in[k].rem = rem_v;
         quot_in[k].quo = quo_v;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            item_ff[k] <= prev_item;
            quot_ff[k] <= quot_in[k];
         end
      end
   end

   assign out_valid = valid_ff[NST-1];
   assign out_item  = item_ff[NST-1];
   assign out_quot  = quot_ff[NST-1];

endmodule

/* sv/pkvsm_slot.sv */
// Block table access, slot multiply and result register of the slot mapper.
// Depends on pkvsm_pkg and pkvsm_ram; writes and reads share one table stage.
module pkvsm_slot (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  pkvsm_pkg::cfg_type              cfg,
   input  logic                            in_valid,
   input  pkvsm_pkg::item_type             in_item,
   input  pkvsm_pkg::quot_type             in_quot,
   output logic                            rsp_valid,
   output logic [pkvsm_pkg::REQ_W-1:0]     rsp_request_echo,
   output logic                            rsp_padded,
   output logic [pkvsm_pkg::POS_W-1:0]     rsp_next_position,
   output logic [pkvsm_pkg::SLOT_W-1:0]    rsp_slot,
   output logic [pkvsm_pkg::SEQ_W-1:0]     rsp_new_seq_length
);

   localparam int ADDR_W = $clog2(pkvsm_pkg::TABLE_DEPTH);

   logic [pkvsm_pkg::TBL_COL_BITS-1:0]   bnum;
   logic [ADDR_W-1:0]                    rd_addr;
   logic [ADDR_W-1:0]                    wr_addr;
   logic                                 rd_en;
   logic                                 wr_en;
   logic                                 wr_in_range;
   logic [pkvsm_pkg::BLOCK_ID_BITS-1:0]  rd_data;

   logic                                 tbl_valid_ff;
   pkvsm_pkg::item_type                  tbl_item_ff;
   logic [pkvsm_pkg::BS_W-1:0]           tbl_rem_ff;

   logic                                 mul_valid_ff;
   pkvsm_pkg::item_type                  mul_item_ff;
   logic [pkvsm_pkg::BS_W-1:0]           mul_rem_ff;
   logic [pkvsm_pkg::PROD_W-1:0]         prod_ff;
   logic [pkvsm_pkg::PROD_W-1:0]         prod_in;

   logic                                 rsp_valid_ff;
   logic [pkvsm_pkg::REQ_W-1:0]          rsp_request_ff;
   logic                                 rsp_padded_ff;
   logic [pkvsm_pkg::POS_W-1:0]          rsp_pos_ff;
   logic [pkvsm_pkg::SLOT_W-1:0]         rsp_slot_ff;
   logic [pkvsm_pkg::SLOT_W-1:0]         rsp_slot_in;
   logic [pkvsm_pkg::SEQ_W-1:0]          rsp_seq_ff;

   // Column is the quotient capped at the last block in use.
   assign bnum = (in_quot.quo > pkvsm_pkg::POS_W'(cfg.last_column)) ?
                 cfg.last_column : in_quot.quo[pkvsm_pkg::TBL_COL_BITS-1:0];

   assign rd_addr     = {in_item.request[pkvsm_pkg::ROW_BITS-1:0], bnum};
   assign wr_addr     = {in_item.request[pkvsm_pkg::ROW_BITS-1:0],
                         in_item.column[pkvsm_pkg::TBL_COL_BITS-1:0]};
   assign wr_in_range = (32'(in_item.request) < pkvsm_pkg::MAX_REQUESTS) &&
                        (32'(in_item.column) < pkvsm_pkg::MAX_BLOCKS_PER_REQUEST);
   assign rd_en       = advance && in_valid && (in_item.kind == pkvsm_pkg::KIND_COMPUTE);
   assign wr_en       = advance && in_valid && (in_item.kind == pkvsm_pkg::KIND_WRITE) &&
                        wr_in_range;

   pkvsm_ram #(
      .WIDTH (pkvsm_pkg::BLOCK_ID_BITS),
      .DEPTH (pkvsm_pkg::TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (in_item.entry[pkvsm_pkg::BLOCK_ID_BITS-1:0]),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign prod_in = pkvsm_pkg::PROD_W'(rd_data) * pkvsm_pkg::PROD_W'(cfg.block_size);

   always_comb begin
      if (mul_item_ff.padded || mul_item_ff.wrap) begin
         rsp_slot_in = {{(pkvsm_pkg::SLOT_W - pkvsm_pkg::PAD_W){cfg.pad_value[pkvsm_pkg::PAD_W-1]}},
                        cfg.pad_value};
      end else begin
         rsp_slot_in = pkvsm_pkg::SLOT_W'(prod_ff) + pkvsm_pkg::SLOT_W'(mul_rem_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tbl_valid_ff <= 1'b0;
         mul_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         tbl_valid_ff <= in_valid;
         mul_valid_ff <= tbl_valid_ff;
         // Table writes end here and give no result.
         rsp_valid_ff <= mul_valid_ff && (mul_item_ff.kind == pkvsm_pkg::KIND_COMPUTE);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tbl_item_ff    <= in_item;
         tbl_rem_ff     <= in_quot.rem;
         mul_item_ff    <= tbl_item_ff;
         mul_rem_ff     <= tbl_rem_ff;
         prod_ff        <= prod_in;
         rsp_request_ff <= mul_item_ff.request;
         rsp_padded_ff  <= mul_item_ff.padded;
         rsp_pos_ff     <= mul_item_ff.next_pos;
         rsp_slot_ff    <= rsp_slot_in;
         rsp_seq_ff     <= mul_item_ff.new_seq;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_request_echo   = rsp_request_ff;
   assign rsp_padded         = rsp_padded_ff;
   assign rsp_next_position  = rsp_pos_ff;
   assign rsp_slot           = rsp_slot_ff;
   assign rsp_new_seq_length = rsp_seq_ff;

endmodule

/* sv/paged_kv_slot_mapper_core.sv */
// Paged KV-cache slot mapper, top level.
// Depends on pkvsm_pkg, pkvsm_csr, pkvsm_prep, pkvsm_div and pkvsm_slot.
//
// The req_ channel carries two kinds of items. A table write (kind 0) stores
// entry_block at row request, column table_column of the block table and
// gives no result. A compute item (kind 1) gives one rsp_ transfer with the
// next position, the cache slot and the updated sequence length, or the pad
// slot when the request is at or beyond the active count or the position wraps.
// A transfer happens on an edge where valid is high and stall is low.
// The pipeline takes one item per cycle while it is not stalled. A result
// reaches rsp_ through the input register, update stage, 12 divider stages
// of 2 quotient bits each, table read, multiply and the result register.
// Writes pass through the same stages, so table reads and writes keep order.
// When rsp_stall holds a waiting result, the whole pipeline freezes and
// req_stall rises in the same cycle; nothing is lost or repeated.
// The csr_ port holds block_size, max_model_len, blocks_per_request,
// pad_value and active_requests at byte addresses 0, 4, 8, 12 and 16; write
// it only while the pipeline is empty. Reset restores the register defaults
// and empties the pipeline; block table contents are undefined until written.
module paged_kv_slot_mapper_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_kind,
   input  logic [pkvsm_pkg::REQ_W-1:0]          req_request,
   input  logic [pkvsm_pkg::COL_W-1:0]          req_table_column,
   input  logic [pkvsm_pkg::ENTRY_W-1:0]        req_entry_block,
   input  logic [pkvsm_pkg::POS_W-1:0]          req_position,
   input  logic [pkvsm_pkg::SEQ_W-1:0]          req_seq_length,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [pkvsm_pkg::REQ_W-1:0]          rsp_request_echo,
   output logic                                 rsp_padded,
   output logic [pkvsm_pkg::POS_W-1:0]          rsp_next_position,
   output logic signed [pkvsm_pkg::SLOT_W-1:0]  rsp_slot,
   output logic [pkvsm_pkg::SEQ_W-1:0]          rsp_new_seq_length,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [pkvsm_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [pkvsm_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [pkvsm_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                 csr_pready
);

   pkvsm_pkg::cfg_type               cfg;
   logic                             advance;
   logic                             prep_valid;
   pkvsm_pkg::item_type              prep_item;
   logic                             div_valid;
   pkvsm_pkg::item_type              div_item;
   pkvsm_pkg::quot_type              div_quot;
   logic [pkvsm_pkg::SLOT_W-1:0]     slot_value;

   // Every stage moves unless a finished result is held by the receiver.
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;
   assign rsp_slot  = slot_value;

   pkvsm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pkvsm_prep u_prep (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .req_valid        (req_valid),
      .req_kind         (req_kind),
      .req_request      (req_request),
      .req_table_column (req_table_column),
      .req_entry_block  (req_entry_block),
      .req_position     (req_position),
      .req_seq_length   (req_seq_length),
      .cfg              (cfg),
      .out_valid        (prep_valid),
      .out_item         (prep_item)
   );

   pkvsm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .divisor   (cfg.block_size),
      .in_valid  (prep_valid),
      .in_item   (prep_item),
      .out_valid (div_valid),
      .out_item  (div_item),
      .out_quot  (div_quot)
   );

   pkvsm_slot u_slot (
      .clock              (clock),
      .reset              (reset),
      .advance            (advance),
      .cfg                (cfg),
      .in_valid           (div_valid),
      .in_item            (div_item),
      .in_quot            (div_quot),
      .rsp_valid          (rsp_valid),
      .rsp_request_echo   (rsp_request_echo),
      .rsp_padded         (rsp_padded),
      .rsp_next_position  (rsp_next_position),
      .rsp_slot           (slot_value),
      .rsp_new_seq_length (rsp_new_seq_length)
   );

endmodule
